FILE: design/tsvcs_pkg.sv
package tsvcs_pkg;

  localparam int unsigned MAX_FIELDS_DEF = 64;
  localparam int unsigned MASK_W         = 64;
  localparam int unsigned BYTE_W         = 8;

  localparam logic [BYTE_W-1:0] CH_TAB     = 8'd9;
  localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'd10;
  localparam logic [BYTE_W-1:0] CH_HASH    = 8'd35;

  localparam logic [MASK_W-1:0] MASK_RESET = {MASK_W{1'b1}};

  // Decision for one byte: whether a byte is emitted, and which.
  typedef struct packed {
    logic              emit;
    logic [BYTE_W-1:0] data;
  } tsvcs_result_t;

endpackage

FILE: design/tsvcs_field_ctl.sv
module tsvcs_field_ctl import tsvcs_pkg::*; #(
  parameter int unsigned MAX_FIELDS = MAX_FIELDS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [BYTE_W-1:0]   byte_in,
  input  logic [MASK_W-1:0]   mask,
  output tsvcs_result_t       result
);

  localparam int unsigned FNUM_W = $clog2(MAX_FIELDS + 1);
  localparam int unsigned IDX_W  = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1;
  localparam logic [FNUM_W-1:0] FNUM_MAX = FNUM_W'(MAX_FIELDS);

  logic [FNUM_W-1:0] field_num_r, field_num_nxt;
  logic              line_start_r, line_start_nxt;
  logic              comment_r, comment_nxt;
  logic              emitted_r, emitted_nxt;

  logic [MAX_FIELDS-1:0] sel_vec;
  logic [FNUM_W-1:0]     field_inc;
  logic                  sel_cur, sel_inc, sel_first, had_field;
  logic                  is_tab, is_nl, is_hash;

  assign sel_vec = mask[MAX_FIELDS-1:0];

  // Fields at or past MAX_FIELDS are never selected.
  function automatic logic field_sel(input logic [MAX_FIELDS-1:0] v,
                                     input logic [FNUM_W-1:0] f);
    logic [IDX_W-1:0] idx;
    idx = IDX_W'(f);
    return (f < FNUM_MAX) && v[idx];
  endfunction

  assign is_tab  = (byte_in == CH_TAB);
  assign is_nl   = (byte_in == CH_NEWLINE);
  assign is_hash = (byte_in == CH_HASH);

  assign field_inc = (field_num_r < FNUM_MAX) ? field_num_r + FNUM_W'(1) : field_num_r;
  assign sel_cur   = field_sel(sel_vec, field_num_r);
  assign sel_inc   = field_sel(sel_vec, field_inc);
  assign sel_first = field_sel(sel_vec, '0);
  assign had_field = emitted_r | (line_start_r & sel_first);

  always_comb begin
    field_num_nxt  = field_num_r;
    line_start_nxt = 1'b0;
    comment_nxt    = comment_r;
    emitted_nxt    = emitted_r;
    result.emit    = 1'b0;
    result.data    = byte_in;
    if (line_start_r && is_hash) begin
      comment_nxt = 1'b1;
    end else if (comment_r) begin
      if (is_nl) begin
        field_num_nxt  = '0;
        line_start_nxt = 1'b1;
        comment_nxt    = 1'b0;
        emitted_nxt    = 1'b0;
      end
    end else if (is_nl) begin
      field_num_nxt  = '0;
      line_start_nxt = 1'b1;
      emitted_nxt    = 1'b0;
      result.emit    = 1'b1;
      result.data    = CH_NEWLINE;
    end else if (is_tab) begin
      field_num_nxt = field_inc;
      emitted_nxt   = had_field | sel_inc;
      result.emit   = had_field & sel_inc;
      result.data   = CH_TAB;
    end else begin
      emitted_nxt = had_field;
      result.emit = sel_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_num_r  <= '0;
      line_start_r <= 1'b1;
      comment_r    <= 1'b0;
      emitted_r    <= 1'b0;
    end else if (step) begin
      field_num_r  <= field_num_nxt;
      line_start_r <= line_start_nxt;
      comment_r    <= comment_nxt;
      emitted_r    <= emitted_nxt;
    end
  end

endmodule

FILE: design/tsv_column_selector.sv
// Path: an accepted byte is held in the input register, then whatever it produces is
// loaded into the output register and offered on out_*.
// Throughput: one byte per cycle while out_ready is high; a held output beat stalls the input register.
// Reset (rst_n, synchronous, active low): the select mask returns to all ones and
// the line tracker returns to the start of a line, field zero, outside any comment.
// No clearing pass is needed; the block takes beats from the first cycle after reset.
module tsv_column_selector import tsvcs_pkg::*; #(
  parameter int unsigned MAX_FIELDS = MAX_FIELDS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] in_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [BYTE_W-1:0] out_byte,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [MASK_W-1:0] cfg_select_mask
);

  // Select mask register. Software must write it only while the stream is idle;
  // the block does not enforce this. The register is always ready to take a beat.
  logic [MASK_W-1:0] mask_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= MASK_RESET;
    end else if (cfg_valid) begin
      mask_r <= cfg_select_mask;
    end
  end

  // Input register. The held byte is processed once the output register can
  // take whatever it produces; bytes that produce nothing still need that
  // slot only for the cycle in which they pass, so the pipe keeps moving.
  logic              in_vld_r;
  logic [BYTE_W-1:0] in_byte_r;
  logic              out_vld_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic              step;
  tsvcs_result_t     res;

  assign step     = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_byte_r <= in_byte;
    end
  end

  // Line and field tracking, plus the per-byte emit decision.
  tsvcs_field_ctl #(
    .MAX_FIELDS (MAX_FIELDS)
  ) u_field_ctl (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .byte_in (in_byte_r),
    .mask    (mask_r),
    .result  (res)
  );

  // Output register. It is loaded whenever a byte is processed, valid only
  // when that byte produced something; otherwise it drains on out_ready.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (step) begin
      out_vld_r <= res.emit;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res.emit) begin
      out_byte_r <= res.data;
    end
  end

  assign out_valid = out_vld_r;
  assign out_byte  = out_byte_r;

endmodule

FILE: dv/tsv_column_selector_checker.sv
`timescale 1ns / 100ps

// Watches the three channels of the column selector, keeps its own copy of the
// line tracker and the select mask, and compares every output beat with the
// oldest predicted byte.
module tsv_column_selector_checker import tsvcs_pkg::*; #(
  parameter int unsigned MAX_FIELDS = MAX_FIELDS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [BYTE_W-1:0] in_byte,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [BYTE_W-1:0] out_byte,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [MASK_W-1:0] cfg_select_mask,
  output int unsigned       fail_count,
  output int unsigned       pending
);

  logic [MASK_W-1:0] sel_mask;
  logic [6:0]        col_num;
  logic              line_start;
  logic              comment_line;
  logic              col_opened;
  logic [BYTE_W-1:0] expected_bytes[$];

  function automatic logic col_picked(input logic [6:0] f);
    if (f >= MAX_FIELDS || f > 7'd63) return 1'b0;
    return sel_mask[f[5:0]];
  endfunction

  function automatic void start_line();
    col_num      = '0;
    line_start   = 1'b1;
    comment_line = 1'b0;
    col_opened   = 1'b0;
  endfunction

  // Advances the line tracker by one byte and says whether a byte goes out.
  function automatic tsvcs_result_t cut_byte(input logic [BYTE_W-1:0] b);
    tsvcs_result_t r;
    logic          had;
    r = '0;
    if (line_start) begin
      line_start = 1'b0;
      if (b == CH_HASH) begin
        comment_line = 1'b1;
        return r;
      end
      if (col_picked(7'd0)) col_opened = 1'b1;
    end
    if (comment_line) begin
      if (b == CH_NEWLINE) start_line();
      return r;
    end
    if (b == CH_NEWLINE) begin
      start_line();
      r.emit = 1'b1;
      r.data = CH_NEWLINE;
      return r;
    end
    if (b == CH_TAB) begin
      had = col_opened;
      if (col_num < MAX_FIELDS) col_num = col_num + 7'd1;
      if (col_picked(col_num)) begin
        col_opened = 1'b1;
        if (had) begin
          r.emit = 1'b1;
          r.data = CH_TAB;
        end
      end
      return r;
    end
    if (col_picked(col_num)) begin
      r.emit = 1'b1;
      r.data = b;
    end
    return r;
  endfunction

  always @(posedge clk) begin : check_beats
    tsvcs_result_t     res;
    logic [BYTE_W-1:0] want;
    if (!rst_n) begin
      sel_mask = MASK_RESET;
      start_line();
      expected_bytes.delete();
      fail_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected output beat, expected none, actual out_byte %0h",
                   $time, out_byte);
          fail_count++;
        end else begin
          want = expected_bytes.pop_front();
          if (out_byte !== want) begin
            $display("%0t: out_byte mismatch, expected %0h, actual %0h",
                     $time, want, out_byte);
            fail_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) sel_mask = cfg_select_mask;
      if (in_valid && in_ready) begin
        res = cut_byte(in_byte);
        if (res.emit) expected_bytes.push_back(res.data);
      end
    end
    pending = expected_bytes.size();
  end

endmodule

FILE: dv/tb_tsv_column_selector.sv
`timescale 1ns / 100ps

// Testbench for the tab-separated column selector. The top only makes
// stimulus and gives the verdict; the checker beside the block predicts every
// output beat from the input beats and mask writes that it sees.
module tb_tsv_column_selector import tsvcs_pkg::*;;

  // A byte passes the input and output registers before it can be taken; the
  // drain wait also covers a byte in flight that turns out to produce nothing.
  localparam int DRAIN_CYCLES = 6;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int PHASE_BEATS  = 120;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [BYTE_W-1:0] in_byte;
  logic              out_valid;
  logic              out_ready;
  logic [BYTE_W-1:0] out_byte;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [MASK_W-1:0] cfg_select_mask;
  int unsigned       fail_count;
  int unsigned       pending;

  // Idle chances in per cent for the sender and the receiver.
  int                send_idle;
  int                recv_idle;
  int unsigned       beats_sent;
  int unsigned       cycles;

  tsv_column_selector dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_byte         (in_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_select_mask (cfg_select_mask)
  );

  tsv_column_selector_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_byte         (in_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_select_mask (cfg_select_mask),
    .fail_count      (fail_count),
    .pending         (pending)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // The receiver decides afresh at every falling edge whether it will take a
  // beat at the next rising edge.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle);
  end

  // Hard stop: a hung handshake or a lost beat ends the run as a failure.
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tsv_column_selector test failed");
    $finish;
  end

  // Offers one input beat. It is entered and left at a falling edge; valid is
  // left high after acceptance so that back-to-back beats need no dip.
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Holds the sender back until every predicted byte has come out, then lets
  // a byte that produces nothing work its way through as well.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Mask writes only happen with the block drained.
  task automatic write_mask(input logic [MASK_W-1:0] m);
    cfg_valid       <= 1'b1;
    cfg_select_mask <= m;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Field content: mostly random text, with zero, carriage return, '#' and
  // 0xFF pushed in often. Tab and newline are never content.
  function automatic logic [BYTE_W-1:0] field_char();
    logic [BYTE_W-1:0] c;
    case ($urandom_range(0, 9))
      0: c = 8'h00;
      1: c = 8'h0D;
      2: c = CH_HASH;
      3: c = 8'hFF;
      default: begin
        do c = 8'($urandom); while (c == CH_TAB || c == CH_NEWLINE);
      end
    endcase
    return c;
  endfunction

  // The mask for one phase of the random part. Each kind comes up twice.
  function automatic logic [MASK_W-1:0] phase_mask(input int p);
    logic [MASK_W-1:0] m;
    case (p % 6)
      0: m = '0;
      1: m = '1;
      2: m = {$urandom, $urandom};
      3: m = 64'h8000_0000_0000_0001;
      4: m = {56'h0, 8'($urandom)};
      default: m = 64'd1 << $urandom_range(1, 7);
    endcase
    return m;
  endfunction

  // One line of random content. Most are well-formed data lines of up to
  // eight fields; the rest are comment lines, empty lines, a few very long
  // lines, some of which run the field counter into saturation, and raw noise
  // that can break a line anywhere.
  task automatic send_random_line();
    int kind;
    int nf;
    int len;
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      send_byte(CH_HASH);
      len = $urandom_range(0, 6);
      repeat (len) send_byte(($urandom_range(0, 3) == 0) ? CH_TAB : field_char());
      send_byte(CH_NEWLINE);
    end else if (kind < 14) begin
      send_byte(CH_NEWLINE);
    end else if (kind < 19) begin
      len = $urandom_range(1, 6);
      repeat (len) send_byte(8'($urandom_range(0, 255)));
    end else begin
      nf = (kind < 22) ? $urandom_range(60, 70) : $urandom_range(1, 8);
      for (int f = 0; f < nf; f++) begin
        if (f != 0) send_byte(CH_TAB);
        len = (nf > 8) ? $urandom_range(0, 1) : $urandom_range(0, 3);
        repeat (len) send_byte(field_char());
      end
      send_byte(CH_NEWLINE);
    end
    // Now and then the sender stops until everything has come out.
    if ($urandom_range(0, 99) < 3) wait_drained();
  endtask

  initial begin
    int unsigned target;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_byte         = '0;
    out_ready       = 1'b0;
    cfg_valid       = 1'b0;
    cfg_select_mask = '0;
    send_idle       = 29;
    recv_idle       = 86;
    beats_sent      = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed lines under the reset mask, which selects every field: a
    // comment line holding a tab, an empty line, an empty field in the
    // middle, a '#' that is not at the start of a line, and the byte values
    // 0xFF, zero and carriage return as plain content.
    send_text("#x\t\n");
    send_text("\n");
    send_text("a\t\tb\n");
    send_text("a#\n");
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h0D);
    send_byte(CH_NEWLINE);

    // Only field one selected: a line too short to reach it gives just its
    // newline, and an empty first field is not joined in front of it.
    wait_drained();
    write_mask(64'h2);
    send_text("x\n");
    send_text("\ty\n");

    // Nothing selected: a data line gives only its newline.
    wait_drained();
    write_mask('0);
    send_text("ab\tc\n");

    // Random part: three idling regimes, four masks in each.
    for (int mode = 0; mode < 3; mode++) begin
      for (int k = 0; k < 4; k++) begin
        wait_drained();
        case (mode)
          0: begin
            send_idle = 29;
            recv_idle = 86;
          end
          1: begin
            send_idle = 86;
            recv_idle = 29;
          end
          default: begin
            send_idle = 0;
            recv_idle = 0;
          end
        endcase
        write_mask(phase_mask(mode * 4 + k));
        target = beats_sent + PHASE_BEATS;
        while (beats_sent < target) send_random_line();
      end
    end

    // Let everything come out, then watch a little longer for strays.
    wait_drained();
    if (fail_count == 0 && pending == 0) begin
      $display("tsv_column_selector test passed");
    end else begin
      $display("tsv_column_selector test failed");
    end
    $finish;
  end

endmodule

FILE: files.f
design/tsvcs_pkg.sv
design/tsvcs_field_ctl.sv
design/tsv_column_selector.sv
dv/tsv_column_selector_checker.sv
dv/tb_tsv_column_selector.sv
